@@ hdl/lrfs_pkg.sv @@
package lrfs_pkg;

    // Coordinate and register widths
    localparam int COORD_BITS   = 20;
    localparam int RANGE_BITS   = 20;
    localparam int RADIUS_BITS  = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 20;
    localparam int MAX_KEPT_DEF = 256;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_RANGE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RANGE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TILT_ON   = 3'd3;

    // Rotation by 0.205 degrees: cosine and sine in Q30
    localparam int FRAC_BITS = 30;
    localparam logic [29:0] C_Q30 = 30'd1073734951;
    localparam logic [21:0] S_Q30 = 22'd3841759;
    // Split point of the quotient for the two partial products
    localparam int Q_SPLIT = 24;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        logic   scan_end;
    } point_in_t;

    typedef struct packed {
        logic   kept;
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
        logic   store_overflow;
        logic   scan_done;
    } result_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // Candidate travelling along the row of store cells
    typedef struct packed {
        logic   active;
        logic   hit;
        point_t pt;
    } cand_t;

    function automatic logic [COORD_BITS-1:0] coord_mag(input coord_t v);
        return v[COORD_BITS-1] ? COORD_BITS'(-v) : COORD_BITS'(v);
    endfunction

endpackage

@@ hdl/lrfs_tilt.sv @@
module lrfs_tilt
    import lrfs_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  point_t                    pt_in,
    input  logic [2*COORD_BITS-1:0]   rxy,
    output logic                      done,
    output point_t                    pt_out
);

    localparam int CB     = COORD_BITS;
    localparam int RW     = CB + 8;
    localparam int RAD_W  = 2 * RW;
    localparam int ZSW    = CB + 21;
    localparam int NW     = ZSW + 8;
    localparam int QW     = ZSW;
    localparam int QH_W   = QW - Q_SPLIT;
    localparam int TW     = ZSW;
    localparam int PW     = CB + QW;
    localparam int VW     = CB + 31;
    localparam int CNT_W  = $clog2(NW);
    localparam logic [VW-1:0] ROUND_HALF = VW'(1) << (FRAC_BITS - 1);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_SQRT = 3'd1;
    localparam logic [2:0] T_DIV  = 3'd2;
    localparam logic [2:0] T_MUL  = 3'd3;
    localparam logic [2:0] T_SUM  = 3'd4;
    localparam logic [2:0] T_RND  = 3'd5;

    logic [2:0]         tstate_reg, tstate_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    point_t             pt_reg, pt_out_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [RW+1:0]      srem_reg, srem_next;
    logic [RW-1:0]      root_reg;
    logic [RW-1:0]      drem_reg, drem_next;
    logic [ZSW-1:0]     zs_reg;
    logic [NW-1:0]      num_reg;
    logic [QW-1:0]      q_reg;
    logic [CB+QH_W-1:0]    pxh_reg, pyh_reg;
    logic [CB+Q_SPLIT-1:0] pxl_reg, pyl_reg;
    logic signed [VW-1:0]  xc_reg, yc_reg, zc_reg;
    logic [RW+21:0]     rs_reg;
    logic [TW-1:0]      tx_reg, ty_reg;

    logic [RW+3:0]      rem_sh, trial;
    logic               sq_ge;
    logic [RW:0]        dsh;
    logic               dv_ge;
    logic [CB+21:0]     zs_full;
    logic [CB-1:0]      ax, ay;
    logic [PW-1:0]      tx_full, ty_full;
    logic signed [VW-1:0] vx, vy, vz;
    logic               x_differ, y_differ;

    function automatic coord_t round_sat(input logic signed [VW-1:0] v);
        logic [VW-1:0] w;
        logic [CB:0]   r;
        w = VW'(v) + ROUND_HALF;
        r = w[VW-1:FRAC_BITS];
        if (r[CB] != r[CB-1]) begin
            return r[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        end
        return coord_t'(r[CB-1:0]);
    endfunction

    // Square root step: one result bit per cycle
    always_comb begin
        rem_sh    = {srem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        sq_ge     = rem_sh >= trial;
        srem_next = sq_ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
    end

    // Restoring division step: one quotient bit per cycle
    always_comb begin
        dsh       = {drem_reg, num_reg[NW-1]};
        dv_ge     = dsh >= {1'b0, root_reg};
        drem_next = dv_ge ? RW'(dsh - {1'b0, root_reg}) : RW'(dsh);
    end

    assign zs_full  = coord_mag(pt_in.z) * S_Q30;
    assign ax       = coord_mag(pt_reg.x);
    assign ay       = coord_mag(pt_reg.y);
    assign tx_full  = {pxh_reg, {Q_SPLIT{1'b0}}} + PW'(pxl_reg);
    assign ty_full  = {pyh_reg, {Q_SPLIT{1'b0}}} + PW'(pyl_reg);
    assign x_differ = pt_reg.x[CB-1] ^ pt_reg.z[CB-1];
    assign y_differ = pt_reg.y[CB-1] ^ pt_reg.z[CB-1];
    assign vx = x_differ ? xc_reg + $signed(VW'(tx_reg)) : xc_reg - $signed(VW'(tx_reg));
    assign vy = y_differ ? yc_reg + $signed(VW'(ty_reg)) : yc_reg - $signed(VW'(ty_reg));
    assign vz = zc_reg + $signed(VW'(rs_reg[RW+21:8]));

    always_comb begin
        tstate_next = tstate_reg;
        unique case (tstate_reg)
            T_IDLE: if (start) tstate_next = T_SQRT;
            T_SQRT: if (cnt_reg == '0) tstate_next = T_DIV;
            T_DIV:  if (cnt_reg == '0) tstate_next = T_MUL;
            T_MUL:  tstate_next = T_SUM;
            T_SUM:  tstate_next = T_RND;
            T_RND:  tstate_next = T_IDLE;
            default: tstate_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tstate_reg <= T_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end else begin
            tstate_reg <= tstate_next;
            done_reg   <= (tstate_reg == T_RND);
            if (tstate_reg == T_IDLE && start) begin
                cnt_reg <= CNT_W'(RW - 1);
            end else if (tstate_reg == T_SQRT && cnt_reg == '0) begin
                cnt_reg <= CNT_W'(NW - 1);
            end else if (tstate_reg == T_SQRT || tstate_reg == T_DIV) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (tstate_reg)
            T_IDLE: begin
                if (start) begin
                    pt_reg   <= pt_in;
                    rad_reg  <= {rxy, {(RAD_W-2*CB){1'b0}}};
                    srem_reg <= '0;
                    root_reg <= '0;
                    zs_reg   <= zs_full[ZSW-1:0];
                end
            end
            T_SQRT: begin
                srem_reg <= srem_next;
                root_reg <= {root_reg[RW-2:0], sq_ge};
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                if (cnt_reg == '0) begin
                    num_reg  <= {zs_reg, {(NW-ZSW){1'b0}}};
                    drem_reg <= '0;
                end
            end
            T_DIV: begin
                drem_reg <= drem_next;
                q_reg    <= {q_reg[QW-2:0], dv_ge};
                num_reg  <= {num_reg[NW-2:0], 1'b0};
            end
            T_MUL: begin
                pxh_reg <= ax * q_reg[QW-1:Q_SPLIT];
                pxl_reg <= ax * q_reg[Q_SPLIT-1:0];
                pyh_reg <= ay * q_reg[QW-1:Q_SPLIT];
                pyl_reg <= ay * q_reg[Q_SPLIT-1:0];
                xc_reg  <= $signed(pt_reg.x) * $signed({1'b0, C_Q30});
                yc_reg  <= $signed(pt_reg.y) * $signed({1'b0, C_Q30});
                zc_reg  <= $signed(pt_reg.z) * $signed({1'b0, C_Q30});
                rs_reg  <= root_reg * S_Q30;
            end
            T_SUM: begin
                tx_reg <= tx_full[TW-1:0];
                ty_reg <= ty_full[TW-1:0];
            end
            T_RND: begin
                pt_out_reg.x <= round_sat(vx);
                pt_out_reg.y <= round_sat(vy);
                pt_out_reg.z <= round_sat(vz);
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign pt_out = pt_out_reg;

endmodule

@@ hdl/lrfs_cell.sv @@
module lrfs_cell
    import lrfs_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 9
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cand_t                    cand_in,
    input  logic [CNT_W-1:0]         kept_count,
    input  logic [2*RADIUS_BITS-1:0] radius_sq,
    output cand_t                    cand_out
);

    localparam int CB    = COORD_BITS;
    localparam int DSQ_W = 2 * CB;
    localparam int SUM_W = DSQ_W + 2;
    localparam int CMP_W = (SUM_W > 2*RADIUS_BITS) ? SUM_W : 2*RADIUS_BITS;

    logic             active_reg, hit_reg, live_reg;
    point_t           pt_reg, store_reg;
    logic [DSQ_W-1:0] dsq_x_reg, dsq_y_reg, dsq_z_reg;
    logic [CB-1:0]    dx, dy, dz;
    logic [SUM_W-1:0] dist_sq;
    logic             near;

    function automatic logic [CB-1:0] diff_mag(input coord_t a, input coord_t b);
        logic signed [CB:0] d;
        d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
        return d[CB] ? CB'(-d) : CB'(d);
    endfunction

    assign dx = diff_mag(cand_in.pt.x, store_reg.x);
    assign dy = diff_mag(cand_in.pt.y, store_reg.y);
    assign dz = diff_mag(cand_in.pt.z, store_reg.z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= cand_in.active;
        end
    end

    always_ff @(posedge aclk) begin
        if (cand_in.active) begin
            hit_reg   <= cand_in.hit;
            pt_reg    <= cand_in.pt;
            live_reg  <= CNT_W'(CELL_IDX) < kept_count;
            dsq_x_reg <= dx * dx;
            dsq_y_reg <= dy * dy;
            dsq_z_reg <= dz * dz;
        end
        // The first empty slot takes a candidate that no earlier entry rejected.
        if (cand_in.active && !cand_in.hit && kept_count == CNT_W'(CELL_IDX)) begin
            store_reg <= cand_in.pt;
        end
    end

    assign dist_sq = SUM_W'(dsq_x_reg) + SUM_W'(dsq_y_reg) + SUM_W'(dsq_z_reg);
    assign near    = live_reg && (CMP_W'(dist_sq) < CMP_W'(radius_sq));

    always_comb begin
        cand_out.active = active_reg;
        cand_out.hit    = hit_reg | near;
        cand_out.pt     = pt_reg;
    end

endmodule

@@ hdl/lidar_range_filter_subsample_core.sv @@
// LiDAR point range filter with optional 0.205 degree tilt correction and greedy radius
// subsampling. Each input word is one point; each produces exactly one result word that
// says whether the point was kept and, if so, carries its corrected coordinates. Points
// are handled one at a time. A point outside the range window goes from the squaring and
// range-check states straight to the done state, which writes its result word to the output
// register once that is free. An in-range point walks the full row of MAX_KEPT store cells,
// one cell per cycle, before it reaches the done state; with tilt correction on and a
// non-zero horizontal radius it first passes through the tilt unit, which runs a bit-serial
// square root and then a bit-serial division. A new point is accepted as soon
// as the previous one has been handed to the output register, even if that result has not
// yet been taken. The kept-point store needs no clearing pass after reset: only entries
// below the fill count are ever compared, and the count returns to zero after the word
// that ends a scan. Configuration registers may only be written while the block is idle.
module lidar_range_filter_subsample_core
    import lrfs_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  point_in_t                s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output result_t                  m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int CB    = COORD_BITS;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);
    localparam int SQ_W  = 2 * CB;
    localparam int RSQ_W = 2 * RANGE_BITS;
    localparam int CMP_W = (SQ_W > RSQ_W) ? SQ_W : RSQ_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_RNG   = 3'd2;
    localparam logic [2:0] ST_TILT  = 3'd3;
    localparam logic [2:0] ST_CHAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Configuration registers
    logic [RANGE_BITS-1:0]    min_range_reg, max_range_reg;
    logic [RADIUS_BITS-1:0]   radius_reg;
    logic                     tilt_on_reg;
    logic [2*RADIUS_BITS-1:0] radius_sq_reg;

    // Sequencer and scan state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next, ovf_now;
    logic             m_valid_reg;
    result_t          m_data_reg;

    // Item datapath
    point_in_t        in_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [RSQ_W-1:0] min_sq_reg, max_sq_reg;
    logic [SQ_W-1:0]  rxy, n2;
    logic             in_rng, use_tilt, tilt_start, tilt_done;
    point_t           tilt_pt, chain_pt, pt_reg;
    logic             chain_go, kept_reg, store_full, out_free;

    cand_t            cand_w [MAX_KEPT+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_range_reg <= '0;
            max_range_reg <= '1;
            radius_reg    <= '0;
            tilt_on_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIN_RANGE: min_range_reg <= cfg_data[RANGE_BITS-1:0];
                REG_MAX_RANGE: max_range_reg <= cfg_data[RANGE_BITS-1:0];
                REG_RADIUS:    radius_reg    <= cfg_data[RADIUS_BITS-1:0];
                REG_TILT_ON:   tilt_on_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The squared radius follows its register in the next cycle; as long as configuration
    // is written only while idle, no point reaches the cells that soon after a write.
    always_ff @(posedge aclk) begin
        radius_sq_reg <= radius_reg * radius_reg;
    end

    // Squared norms are formed in their own cycle, the range window is
    // checked in the next one.
    assign rxy      = sqx_reg + sqy_reg;
    assign n2       = rxy + sqz_reg;
    assign in_rng   = (CMP_W'(n2) > CMP_W'(min_sq_reg)) && (CMP_W'(n2) < CMP_W'(max_sq_reg));
    assign use_tilt = tilt_on_reg && (rxy != '0);

    assign tilt_start = (state_reg == ST_RNG) && in_rng && use_tilt;
    assign chain_go   = ((state_reg == ST_RNG) && in_rng && !use_tilt)
                     || ((state_reg == ST_TILT) && tilt_done);

    always_comb begin
        if (state_reg == ST_TILT) begin
            chain_pt = tilt_pt;
        end else begin
            chain_pt.x = in_reg.point_x;
            chain_pt.y = in_reg.point_y;
            chain_pt.z = in_reg.point_z;
        end
    end

    lrfs_tilt u_tilt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tilt_start),
        .pt_in   (chain_pt),
        .rxy     (rxy),
        .done    (tilt_done),
        .pt_out  (tilt_pt)
    );

    // The candidate enters the row at cell 0 and moves one cell per cycle.
    // Cells below the fill count compare it against their stored point; the
    // cell at the fill count stores it if no earlier cell found it too close.
    // What leaves the last cell carries the final keep decision.
    always_comb begin
        cand_w[0].active = chain_go;
        cand_w[0].hit    = 1'b0;
        cand_w[0].pt     = chain_pt;
    end

    for (genvar gi = 0; gi < MAX_KEPT; gi++) begin : g_row
        lrfs_cell #(
            .CELL_IDX (gi),
            .CNT_W    (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cand_in    (cand_w[gi]),
            .kept_count (count_reg),
            .radius_sq  (radius_sq_reg),
            .cand_out   (cand_w[gi+1])
        );
    end

    // Per-item datapath registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_SQ) begin
            sqx_reg    <= coord_mag(in_reg.point_x) * coord_mag(in_reg.point_x);
            sqy_reg    <= coord_mag(in_reg.point_y) * coord_mag(in_reg.point_y);
            sqz_reg    <= coord_mag(in_reg.point_z) * coord_mag(in_reg.point_z);
            min_sq_reg <= min_range_reg * min_range_reg;
            max_sq_reg <= max_range_reg * max_range_reg;
        end
        if (chain_go) begin
            pt_reg <= chain_pt;
        end
        if (state_reg == ST_RNG && !in_rng) begin
            kept_reg <= 1'b0;
        end else if (state_reg == ST_CHAIN && cand_w[MAX_KEPT].active) begin
            kept_reg <= !cand_w[MAX_KEPT].hit;
        end
    end

    // Scan bookkeeping: a kept point beyond the store's capacity is still
    // passed on, but only raises the sticky overflow flag for this scan.
    assign store_full = count_reg == CNT_W'(MAX_KEPT);
    assign ovf_now    = overflow_reg | (kept_reg & store_full);

    always_comb begin
        if (in_reg.scan_end) begin
            count_next    = '0;
            overflow_next = 1'b0;
        end else begin
            count_next    = (kept_reg && !store_full) ? count_reg + 1'b1 : count_reg;
            overflow_next = ovf_now;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_SQ;
            ST_SQ:    state_next = ST_RNG;
            ST_RNG: begin
                if (!in_rng) begin
                    state_next = ST_DONE;
                end else if (use_tilt) begin
                    state_next = ST_TILT;
                end else begin
                    state_next = ST_CHAIN;
                end
            end
            ST_TILT:  if (tilt_done) state_next = ST_CHAIN;
            ST_CHAIN: if (cand_w[MAX_KEPT].active) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg  <= 1'b1;
                count_reg    <= count_next;
                overflow_reg <= overflow_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output register: dropped points report zero coordinates.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg.kept           <= kept_reg;
            m_data_reg.out_x          <= kept_reg ? pt_reg.x : '0;
            m_data_reg.out_y          <= kept_reg ? pt_reg.y : '0;
            m_data_reg.out_z          <= kept_reg ? pt_reg.z : '0;
            m_data_reg.store_overflow <= ovf_now;
            m_data_reg.scan_done      <= in_reg.scan_end;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
